// ----- rtl/trp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package trp_pkg;

   localparam int TRB_W      = 128;
   localparam int PARAM_W    = 64;
   localparam int STATUS_W   = 32;
   localparam int CONTROL_W  = 32;
   localparam int INDEX_W    = 6;

   localparam logic [5:0]  LINK_TRB_TYPE = 6'd6;
   localparam logic [63:0] ALIGN_MASK    = 64'h3f;
   localparam logic [31:0] TOGGLE_BIT    = 32'h2;

   typedef enum logic [1:0] {
      OP_INIT    = 2'd0,
      OP_ENQUEUE = 2'd1,
      OP_READ    = 2'd2
   } trp_op_type;

   typedef enum logic {
      RC_OK      = 1'b0,
      RC_INVALID = 1'b1
   } trp_rc_type;

   typedef struct packed {
      trp_op_type           op;
      logic [PARAM_W-1:0]   trb_parameter;
      logic [STATUS_W-1:0]  trb_status;
      logic [CONTROL_W-1:0] trb_control;
      logic [INDEX_W-1:0]   entry_index;
   } trp_request_type;

   typedef struct packed {
      trp_rc_type           result_code;
      logic [INDEX_W-1:0]   slot_index;
      logic [PARAM_W-1:0]   read_parameter;
      logic [STATUS_W-1:0]  read_status;
      logic [CONTROL_W-1:0] read_control;
   } trp_result_type;

   function automatic logic [CONTROL_W-1:0] link_control(input logic cycle);
      return ({26'd0, LINK_TRB_TYPE} << 10) | TOGGLE_BIT | {31'd0, cycle};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/trp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module trp_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/trp_ring_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module trp_ring_ctrl import trp_pkg::*; #(
   parameter int RING_ENTRIES = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire trp_request_type req,
   input  wire logic [63:0]     ring_base,
   output logic                 res_valid,
   input  wire logic            res_ready,
   output trp_result_type       res
);

   localparam int AW = $clog2(RING_ENTRIES);
   localparam logic [AW-1:0] LAST = AW'(RING_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_RESP
   } state_type;

   state_type            state_ff;
   logic                 ready_ff;
   logic [AW-1:0]        slot_ff;
   logic                 cyc_ff;
   logic [AW-1:0]        clr_ff;
   logic                 link_pend_ff;
   logic                 link_cyc_ff;
   logic [PARAM_W-1:0]   link_base_ff;
   trp_rc_type           res_rc_ff;
   logic [INDEX_W-1:0]   res_slot_ff;
   logic                 res_read_ff;

   logic                 req_fire;
   logic                 enq_ok;
   logic                 in_range;
   logic [AW-1:0]        slot_next;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [TRB_W-1:0]     mem_wdata;
   logic                 mem_re;
   logic [AW-1:0]        mem_raddr;
   logic [TRB_W-1:0]     mem_rdata;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign enq_ok    = ready_ff && (slot_ff < LAST);
   assign slot_next = slot_ff + 1'b1;
   assign in_range  = 32'(req.entry_index) < 32'(RING_ENTRIES);

   // writes are spaced by the sequencer; a read is never issued in the cycle
   // of a write to the same slot
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = {req.trb_control[31:1], cyc_ff, req.trb_status, req.trb_parameter};
      case (state_ff)
         ST_IDLE: begin
            mem_we = req_fire && (req.op == OP_ENQUEUE) && enq_ok;
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = (clr_ff == LAST) ?
                        {link_control(1'b1), 32'd0, link_base_ff} : '0;
         end
         ST_RESP: begin
            mem_we    = link_pend_ff;
            mem_waddr = LAST;
            mem_wdata = {link_control(link_cyc_ff), 32'd0, link_base_ff};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   assign mem_re    = req_fire && (req.op == OP_READ) && in_range;
   assign mem_raddr = AW'(req.entry_index);

   trp_ram #(
      .WIDTH (TRB_W),
      .DEPTH (RING_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= 1'b0;
         slot_ff      <= '0;
         cyc_ff       <= 1'b1;
         clr_ff       <= '0;
         link_pend_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req.op)
                     OP_INIT: begin
                        res_slot_ff <= '0;
                        res_read_ff <= 1'b0;
                        if ((ring_base & ALIGN_MASK) != '0) begin
                           res_rc_ff <= RC_INVALID;
                           state_ff  <= ST_RESP;
                        end else begin
                           res_rc_ff    <= RC_OK;
                           clr_ff       <= '0;
                           link_base_ff <= ring_base;
                           state_ff     <= ST_CLEAR;
                        end
                     end
                     OP_ENQUEUE: begin
                        res_read_ff <= 1'b0;
                        state_ff    <= ST_RESP;
                        if (enq_ok) begin
                           res_rc_ff   <= RC_OK;
                           res_slot_ff <= INDEX_W'(slot_ff);
                           if (slot_next == LAST) begin
                              slot_ff      <= '0;
                              cyc_ff       <= ~cyc_ff;
                              link_pend_ff <= 1'b1;
                              link_cyc_ff  <= cyc_ff;
                           end else begin
                              slot_ff <= slot_next;
                           end
                        end else begin
                           res_rc_ff   <= RC_INVALID;
                           res_slot_ff <= '0;
                        end
                     end
                     OP_READ: begin
                        res_slot_ff <= '0;
                        state_ff    <= ST_RESP;
                        if (in_range) begin
                           res_rc_ff   <= RC_OK;
                           res_read_ff <= 1'b1;
                        end else begin
                           res_rc_ff   <= RC_INVALID;
                           res_read_ff <= 1'b0;
                        end
                     end
                     default: begin
                        res_rc_ff   <= RC_INVALID;
                        res_slot_ff <= '0;
                        res_read_ff <= 1'b0;
                        state_ff    <= ST_RESP;
                     end
                  endcase
               end
            end
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST) begin
                  ready_ff <= 1'b1;
                  slot_ff  <= '0;
                  cyc_ff   <= 1'b1;
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               link_pend_ff <= 1'b0;
               if (res_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign res_valid          = (state_ff == ST_RESP);
   assign res.result_code    = res_rc_ff;
   assign res.slot_index     = res_slot_ff;
   assign res.read_parameter = res_read_ff ? mem_rdata[63:0]   : '0;
   assign res.read_status    = res_read_ff ? mem_rdata[95:64]  : '0;
   assign res.read_control   = res_read_ff ? mem_rdata[127:96] : '0;

`ifndef SYNTHESIS
   a_link_only_in_resp: assert property (@(posedge clock) disable iff (reset)
      link_pend_ff |-> state_ff == ST_RESP)
      else $error("link rewrite pending outside response state");

   a_slot_advance: assert property (@(posedge clock) disable iff (reset)
      req_fire && req.op == OP_ENQUEUE && enq_ok |=>
      slot_ff == '0 || slot_ff == AW'($past(slot_ff) + 1'b1))
      else $error("enqueue slot did not advance or wrap");

   a_cycle_on_wrap: assert property (@(posedge clock) disable iff (reset)
      cyc_ff != $past(cyc_ff) |-> slot_ff == '0)
      else $error("producer cycle changed without wrap");

   a_init_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && req.op == OP_INIT && (ring_base & ALIGN_MASK) == '0 |=>
      !res_valid && state_ff == ST_CLEAR)
      else $error("init answered before clearing the ring");

   a_write_in_ring: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> mem_waddr <= LAST)
      else $error("store write outside the ring");
`endif

endmodule

`default_nettype wire

// ----- rtl/xhci_transfer_ring_producer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tuser op, tdata TRB words and entry index
// rsp       out  rsp_tvalid/rsp_tready  tuser result code, tdata slot and entry read
// csr       in   csr_valid/csr_ready    csr_data ring base address
//
// Enqueue and read pass through the idle and response states; the single write port of
// the TRB store sets the link TRB rewrite into the response state, after the enqueue write.
// Init clears the ring before it answers: the clearing pass writes one slot a cycle.
// Reset clears ring state only; the store is undefined until the first init.
// A finished result waits in the output register while the next request is taken.

module xhci_transfer_ring_producer import trp_pkg::*; #(
   parameter int RING_ENTRIES = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [135:0] req_tdata,  // trb_parameter, trb_status, trb_control, entry_index
   input  wire logic [1:0]   req_tuser,  // op
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [135:0] rsp_tdata,  // slot_index, read_parameter, read_status, read_control
   output logic      [0:0]   rsp_tuser,  // result_code
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [63:0]  csr_data
);

   logic [63:0]     ring_base_ff;
   trp_request_type req;
   trp_result_type  res;
   logic            res_valid;
   logic            res_ready;
   logic            rsp_valid_ff;
   logic [135:0]    rsp_data_ff;
   logic [0:0]      rsp_user_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         ring_base_ff <= csr_data;
      end
   end

   assign req.op            = trp_op_type'(req_tuser);
   assign req.trb_parameter = req_tdata[63:0];
   assign req.trb_status    = req_tdata[95:64];
   assign req.trb_control   = req_tdata[127:96];
   assign req.entry_index   = req_tdata[133:128];

   trp_ring_ctrl #(
      .RING_ENTRIES (RING_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .ring_base (ring_base_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= {2'b00, res.read_control, res.read_status,
                          res.read_parameter, res.slot_index};
         rsp_user_ff  <= res.result_code;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ----- tb/xhci_transfer_ring_producer_tb.sv -----
`timescale 1ns / 1ps

module xhci_transfer_ring_producer_tb import trp_pkg::*;;

   localparam int          RING_SLOTS    = 64;
   localparam logic [5:0]  LINK_SLOT     = 6'd63;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam int          SETTLE_CYCLES = RING_SLOTS + 8;
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam logic [63:0] TOP_ALIGNED   = 64'hFFFF_FFFF_FFFF_FFC0;

   typedef struct packed {
      logic [63:0] param;
      logic [31:0] status;
      logic [31:0] control;
   } trb_slot_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata   = '0;  // trb_parameter, trb_status, trb_control, entry_index
   logic [1:0]   req_tuser   = '0;  // op
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [135:0] rsp_tdata;         // slot_index, read_parameter, read_status, read_control
   logic [0:0]   rsp_tuser;         // result_code
   logic         csr_valid   = 1'b0;
   logic         csr_ready;
   logic [63:0]  csr_data    = '0;

   // ring shadow
   trb_slot_type   ring_mem [RING_SLOTS];
   logic           ring_armed    = 1'b0;
   logic           store_cleared = 1'b0;
   logic [5:0]     next_slot     = '0;
   logic           cycle_bit     = 1'b1;
   logic [63:0]    base_addr     = '0;
   trp_result_type pending_replies [$];

   logic req_offered     = 1'b0;
   logic no_idle         = 1'b0;
   int   rsp_hold_cycles = 0;
   int   cycle_count     = 0;
   int   mismatch_count  = 0;
   int   checked_count   = 0;
   int   init_count      = 0;
   int   enqueue_count   = 0;
   int   read_count      = 0;
   int   other_count     = 0;
   int   wrap_count      = 0;
   int   base_settings   = 0;

   xhci_transfer_ring_producer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_replies.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] link_word(input logic cyc);
      return ({16'd0, LINK_TRB_TYPE, 10'd0} | TOGGLE_BIT | {31'd0, cyc});
   endfunction

   function automatic trp_result_type predict_ring_reply(input logic [1:0] op,
         input logic [63:0] param, input logic [31:0] status,
         input logic [31:0] control, input logic [5:0] index);
      trp_result_type r;
      r = '0;
      r.result_code = RC_OK;
      case (op)
         OP_INIT: begin
            init_count++;
            if ((base_addr & ALIGN_MASK) != '0) begin
               r.result_code = RC_INVALID;
            end else begin
               foreach (ring_mem[i]) ring_mem[i] = '0;
               ring_mem[LINK_SLOT].param   = base_addr;
               ring_mem[LINK_SLOT].control = link_word(1'b1);
               next_slot     = '0;
               cycle_bit     = 1'b1;
               ring_armed    = 1'b1;
               store_cleared = 1'b1;
            end
         end
         OP_ENQUEUE: begin
            enqueue_count++;
            if (!ring_armed || next_slot >= LINK_SLOT) begin
               r.result_code = RC_INVALID;
            end else begin
               r.slot_index = next_slot;
               ring_mem[next_slot].param   = param;
               ring_mem[next_slot].status  = status;
               ring_mem[next_slot].control = {control[31:1], cycle_bit};
               if (next_slot + 6'd1 == LINK_SLOT) begin
                  ring_mem[LINK_SLOT].control = link_word(cycle_bit);
                  next_slot = '0;
                  cycle_bit = ~cycle_bit;
                  wrap_count++;
               end else begin
                  next_slot = next_slot + 6'd1;
               end
            end
         end
         OP_READ: begin
            read_count++;
            r.read_parameter = ring_mem[index].param;
            r.read_status    = ring_mem[index].status;
            r.read_control   = ring_mem[index].control;
         end
         default: begin
            other_count++;
            r.result_code = RC_INVALID;
         end
      endcase
      return r;
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [63:0] param,
         input logic [31:0] status, input logic [31:0] control, input logic [5:0] index);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         if (req_offered) begin
            req_tvalid  <= 1'b0;
            req_offered = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_tvalid  <= 1'b1;
      req_offered = 1'b1;
      req_tuser   <= op;
      req_tdata   <= {2'b00, index, control, status, param};
      do @(posedge clock); while (!req_tready);
      pending_replies.push_back(predict_ring_reply(op, param, status, control, index));
   endtask

   task automatic send_random_enqueue();
      send_request(OP_ENQUEUE, rand64(), $urandom, $urandom, 6'($urandom_range(0, 63)));
   endtask

   task automatic send_random_read();
      if (store_cleared)
         send_request(OP_READ, rand64(), $urandom, $urandom, 6'($urandom_range(0, 63)));
      else
         send_random_enqueue();
   endtask

   task automatic drain_ring();
      if (req_offered) begin
         req_tvalid  <= 1'b0;
         req_offered = 1'b0;
      end
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ring_base(input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      base_addr = value;
      base_settings++;
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %0s at cycle %0d: expected %h got %h", what, cycle_count,
                  want, got);
   endtask

   task automatic check_reply();
      trp_result_type want;
      checked_count++;
      if (pending_replies.size() == 0) begin
         report_mismatch("result with nothing pending", '0, {63'd0, rsp_tuser[0]});
      end else begin
         want = pending_replies.pop_front();
         if (rsp_tuser[0] !== want.result_code)
            report_mismatch("result_code", 64'(want.result_code), 64'(rsp_tuser[0]));
         if (rsp_tdata[5:0] !== want.slot_index)
            report_mismatch("slot_index", 64'(want.slot_index), 64'(rsp_tdata[5:0]));
         if (rsp_tdata[69:6] !== want.read_parameter)
            report_mismatch("read_parameter", want.read_parameter, rsp_tdata[69:6]);
         if (rsp_tdata[101:70] !== want.read_status)
            report_mismatch("read_status", 64'(want.read_status), 64'(rsp_tdata[101:70]));
         if (rsp_tdata[133:102] !== want.read_control)
            report_mismatch("read_control", 64'(want.read_control),
                            64'(rsp_tdata[133:102]));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_reply();
   end

   // result side: random stalls, or a long hold-off when requested
   always begin : rsp_drive
      int stall;
      if (rsp_hold_cycles > 0) begin
         stall = rsp_hold_cycles;
         rsp_hold_cycles = 0;
      end else begin
         stall = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_tready <= 1'b1;
      do @(posedge clock); while (rsp_tvalid !== 1'b1);
   end

   task automatic test_enqueue_before_init();
      send_random_enqueue();
      send_request(OP_UNUSED, '1, '1, '1, '1);
   endtask

   task automatic test_misaligned_base();
      drain_ring();
      write_ring_base('1);
      send_request(OP_INIT, '0, '0, '0, '0);
      send_random_enqueue();
   endtask

   task automatic test_init_and_field_extremes();
      drain_ring();
      write_ring_base(TOP_ALIGNED);
      send_request(OP_INIT, '1, '1, '1, '1);
      send_request(OP_READ, '0, '0, '0, LINK_SLOT);
      send_request(OP_READ, '1, '1, '1, 6'd0);
      send_request(OP_ENQUEUE, '1, '1, '1, '1);
      send_request(OP_ENQUEUE, '0, '0, '0, '0);
      send_request(OP_READ, '0, '0, '0, 6'd0);
      send_request(OP_READ, '0, '0, '0, 6'd1);
      send_request(OP_READ, '0, '0, '0, 6'd2);
      send_request(OP_UNUSED, '0, '0, '0, '0);
   endtask

   // a rejected init must leave the armed ring untouched
   task automatic test_failed_init_keeps_ring();
      drain_ring();
      write_ring_base(64'h1);
      send_request(OP_INIT, '0, '0, '0, '0);
      send_request(OP_READ, '0, '0, '0, LINK_SLOT);
      send_request(OP_ENQUEUE, 64'h0123_4567_89AB_CDEF, 32'hA5A5_5A5A, 32'hFFFF_FFFE, '0);
      send_request(OP_READ, '0, '0, '0, 6'd2);
   endtask

   task automatic test_random_traffic();
      logic [63:0] base;
      int          pick;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: base = '0;
            1: base = TOP_ALIGNED;
            2: base = 64'h3F;
            3: base = rand64() & ~ALIGN_MASK;
            default: begin
               base = rand64();
               if ($urandom_range(0, 3) != 0) base[5:0] = '0;
               else if (base[5:0] == '0) base[0] = 1'b1;
            end
         endcase
         drain_ring();
         write_ring_base(base);
         no_idle = (phase == 5);
         send_request(OP_INIT, rand64(), $urandom, $urandom, 6'($urandom_range(0, 63)));
         repeat (165) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
               send_random_enqueue();
            else if (pick < 95)
               send_random_read();
            else if (pick < 96)
               send_request(OP_INIT, rand64(), $urandom, $urandom, '0);
            else
               send_request(OP_UNUSED, rand64(), $urandom, $urandom,
                            6'($urandom_range(0, 63)));
         end
      end
      no_idle = 1'b0;
   endtask

   // receiver holds off while requests keep coming, then enough traffic to wrap
   task automatic test_output_backpressure();
      drain_ring();
      write_ring_base(64'h0000_0000_8000_0040);
      no_idle = 1'b1;
      rsp_hold_cycles = 500;
      send_request(OP_INIT, '0, '0, '0, '0);
      repeat (130) begin
         if ($urandom_range(0, 4) != 0) send_random_enqueue();
         else send_random_read();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_enqueue_before_init();
      test_misaligned_base();
      test_init_and_field_extremes();
      test_failed_init_keeps_ring();
      test_random_traffic();
      test_output_backpressure();
      drain_ring();
      mismatch_count += pending_replies.size();
      $display("covered %0d init, %0d enqueue, %0d read, %0d unused-op transactions",
               init_count, enqueue_count, read_count, other_count);
      $display("%0d ring wraps, %0d base settings, %0d results checked, %0d mismatches",
               wrap_count, base_settings, checked_count, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
